// File: rtl/core/dvl_pkg.sv
// shared types and constants for the delta varint list decoder
// no dependencies; imported by every module of the block except dvl_in_stage
package dvl_pkg;

    localparam int REC_W            = 32;
    localparam int SHIFT_LIMIT      = 35;
    localparam int VARINT_MAX_BYTES = SHIFT_LIMIT / 7;
    localparam int IDX_W            = 3;

    localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
    localparam int         CONT_BIT     = 7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_EARLY    = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'b001,
        PH_RECORDS = 3'b010,
        PH_DRAIN   = 3'b100
    } phase_t;

    typedef struct packed {
        logic             emit;
        logic [REC_W-1:0] value;
        logic             valid;
        logic             last;
        logic [1:0]       status;
    } dvl_result_t;

endpackage

// File: rtl/core/dvl_in_stage.sv
// input register for the compressed byte stream
// no package dependencies; feeds dvl_core with one held transaction
module dvl_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       s_eod,
    input  logic       consume,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_eod
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       eod_reg;

    assign s_ready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
            eod_reg  <= s_eod;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_eod   = eod_reg;

endmodule

// File: rtl/core/dvl_core.sv
// varint decode state and per-byte update logic
// depends on dvl_pkg for phase type, status codes and result struct
module dvl_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_eod,
    input  logic                 out_space,
    output logic                 consume,
    output dvl_pkg::dvl_result_t result
);
    import dvl_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [REC_W-1:0]       accum_reg, accum_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [REC_W-1:0]       left_reg, left_next;
    logic [VALUE_WIDTH-1:0] running_reg, running_next;
    logic                   first_reg, first_next;
    logic                   delta_reg;

    logic [4:0]             shamt;
    logic [REC_W-1:0]       acc_new;
    logic                   cont;
    logic                   too_long;
    logic                   done;
    logic [VALUE_WIDTH-1:0] rec_masked;
    logic [VALUE_WIDTH-1:0] rec_val;
    logic                   end_list;
    logic                   restart;

    assign consume = in_valid && out_space;

    always_comb
    begin
        case (idx_reg)
            3'd0:    shamt = 5'd0;
            3'd1:    shamt = 5'd7;
            3'd2:    shamt = 5'd14;
            3'd3:    shamt = 5'd21;
            3'd4:    shamt = 5'd28;
            default: shamt = 5'd0;
        endcase
    end

    // payload bits pushed past bit 31 fall off here
    assign acc_new    = accum_reg | (REC_W'(in_byte[6:0] & PAYLOAD_MASK) << shamt);
    assign cont       = in_byte[CONT_BIT];
    assign too_long   = cont && (idx_reg == IDX_W'(VARINT_MAX_BYTES - 1));
    assign done       = !cont || in_eod;
    assign rec_masked = acc_new[VALUE_WIDTH-1:0];
    assign rec_val    = (delta_reg && !first_reg) ? (running_reg + rec_masked) : rec_masked;

    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        idx_next      = idx_reg;
        left_next     = left_reg;
        running_next  = running_reg;
        first_next    = first_reg;
        end_list      = 1'b0;
        restart       = 1'b0;
        result        = '0;
        result.status = ST_OK;

        if (consume)
        begin
            case (phase_reg)
                PH_DRAIN:
                begin
                    restart = in_eod;
                end
                PH_COUNT, PH_RECORDS:
                begin
                    accum_next = acc_new;
                    idx_next   = idx_reg + IDX_W'(1);
                    if (too_long)
                    begin
                        result.emit   = 1'b1;
                        result.last   = 1'b1;
                        result.status = ST_TOO_LONG;
                        end_list      = 1'b1;
                    end
                    else if (done)
                    begin
                        accum_next = '0;
                        idx_next   = '0;
                        if (phase_reg == PH_COUNT)
                        begin
                            if (acc_new == '0)
                            begin
                                result.emit   = 1'b1;
                                result.last   = 1'b1;
                                result.status = ST_EMPTY;
                                end_list      = 1'b1;
                            end
                            else
                            begin
                                left_next  = acc_new;
                                first_next = 1'b1;
                                phase_next = PH_RECORDS;
                                if (in_eod)
                                begin
                                    result.emit   = 1'b1;
                                    result.last   = 1'b1;
                                    result.status = ST_EARLY;
                                    restart       = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            running_next  = rec_val;
                            first_next    = 1'b0;
                            left_next     = left_reg - REC_W'(1);
                            result.emit   = 1'b1;
                            result.valid  = 1'b1;
                            result.value  = REC_W'(rec_val);
                            if (left_reg == REC_W'(1))
                            begin
                                result.last = 1'b1;
                                end_list    = 1'b1;
                            end
                            else if (in_eod)
                            begin
                                result.last   = 1'b1;
                                result.status = ST_EARLY;
                                restart       = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase

            if (end_list && !in_eod)
            begin
                phase_next = PH_DRAIN;
            end
            if ((end_list && in_eod) || restart)
            begin
                phase_next   = PH_COUNT;
                accum_next   = '0;
                idx_next     = '0;
                left_next    = '0;
                running_next = '0;
                first_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            accum_reg   <= '0;
            idx_reg     <= '0;
            left_reg    <= '0;
            running_reg <= '0;
            first_reg   <= 1'b1;
            delta_reg   <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            idx_reg     <= idx_next;
            left_reg    <= left_next;
            running_reg <= running_next;
            first_reg   <= first_next;
            if (cfg_wr_en)
            begin
                delta_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: rtl/core/dvl_out_stage.sv
// result register driving the record stream
// depends on dvl_pkg for the result struct
module dvl_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dvl_pkg::dvl_result_t      result,
    input  logic                      load,
    output logic                      space,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [dvl_pkg::REC_W-1:0] m_data,
    output logic                      m_last,
    output logic [2:0]                m_user
);
    import dvl_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [REC_W-1:0] value_reg;
    logic             rec_valid_reg;
    logic             last_reg;
    logic [1:0]       status_reg;

    assign space = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && result.emit)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.emit)
        begin
            value_reg     <= result.value;
            rec_valid_reg <= result.valid;
            last_reg      <= result.last;
            status_reg    <= result.status;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = value_reg;
    assign m_last  = last_reg;
    assign m_user  = {status_reg, rec_valid_reg};

endmodule

// File: rtl/core/delta_varint_list_decoder.sv
// path: a byte is registered in the input register, and its result, if any, in the result register
// throughput: one compressed byte per cycle while the result register has space, with the accumulate and gap add
// combinational between the input register and the result register
// reset: rst_n asynchronous active low; clears list state, empties both stages,
// delta_mode returns to 1
module delta_varint_list_decoder #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // delta_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,    // end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] record number
    output logic        m_axis_tlast,    // last_of_list
    output logic [2:0]  m_axis_tuser     // [0] record_valid, [2:1] status
);
    import dvl_pkg::*;

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_eod;
    logic        consume;
    logic        out_space;
    dvl_result_t result;

    dvl_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_byte   (s_axis_tdata),
        .s_eod    (s_axis_tlast),
        .consume  (consume),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_eod   (in_eod)
    );

    dvl_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .in_eod      (in_eod),
        .out_space   (out_space),
        .consume     (consume),
        .result      (result)
    );

    dvl_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .load    (consume),
        .space   (out_space),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast),
        .m_user  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // a result without a record always closes its list with an error or empty code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tlast && (m_axis_tuser[2:1] != ST_OK) && (m_axis_tdata == '0)))
        else $error("record-less result not closing the list");

    // any non-ok status ends the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] != ST_OK)) |-> m_axis_tlast)
        else $error("error status without last_of_list");

    // input stalls only when both stages hold a transaction and the sink is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with room in the pipe");

    // a consumed byte with a result always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && result.emit) |=> m_axis_tvalid)
        else $error("result lost between core and output register");
`endif

endmodule

// File: test/delta_varint_list_decoder_test.sv
// self-checking testbench for delta_varint_list_decoder: directed steps, then random posting lists
// depends on dvl_pkg and the decoder rtl; carries its own predictor of the decoded records
module delta_varint_list_decoder_test;

    import dvl_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        valid;
        logic        last;
        logic [1:0]  status;
    } record_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
        logic       pinned;       // expectation typed in below, predictor output unused
        logic       pinned_has;
        record_t    rec;
    } step_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    // predictor state
    logic        delta_on = 1'b1;
    phase_t      list_phase = PH_COUNT;
    logic [31:0] gathered = '0;
    int unsigned seen_bytes = 0;
    logic [31:0] recs_left = '0;
    logic [31:0] last_rec = '0;
    logic        at_first = 1'b1;

    record_t     expected_recs[$];
    step_t       directed_steps[$];
    logic [7:0]  burst_q[$];
    int          err_count = 0;
    int          live_items = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asks = 0;

    delta_varint_list_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("delta_varint_list_decoder_test: errors");
        $finish;
    end

    task automatic restart_list();
        list_phase = PH_COUNT;
        gathered   = '0;
        seen_bytes = 0;
        recs_left  = '0;
        last_rec   = '0;
        at_first   = 1'b1;
    endtask

    task automatic close_list(input logic eod);
        if (eod)
            restart_list();
        else
            list_phase = PH_DRAIN;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eod,
                               output logic got, output record_t rec);
        logic [31:0] v;
        logic [63:0] part;
        got = 1'b0;
        rec = '0;
        if (list_phase == PH_DRAIN)
        begin
            if (eod)
                restart_list();
        end
        else
        begin
            if (seen_bytes < VARINT_MAX_BYTES)
            begin
                part = 64'(b[6:0]) << (7 * seen_bytes);
                gathered = gathered | part[31:0];
            end
            seen_bytes++;
            if (b[CONT_BIT] && seen_bytes >= VARINT_MAX_BYTES)
            begin
                // too long wins over end of data on the same byte
                got = 1'b1;
                rec = record_t'{32'h0, 1'b0, 1'b1, ST_TOO_LONG};
                close_list(eod);
            end
            else if (!b[CONT_BIT] || eod)
            begin
                v = gathered;
                gathered = '0;
                seen_bytes = 0;
                if (list_phase == PH_COUNT)
                begin
                    if (v == 0)
                    begin
                        got = 1'b1;
                        rec = record_t'{32'h0, 1'b0, 1'b1, ST_EMPTY};
                        close_list(eod);
                    end
                    else
                    begin
                        recs_left  = v;
                        at_first   = 1'b1;
                        list_phase = PH_RECORDS;
                        if (eod)
                        begin
                            got = 1'b1;
                            rec = record_t'{32'h0, 1'b0, 1'b1, ST_EARLY};
                            restart_list();
                        end
                    end
                end
                else
                begin
                    if (delta_on && !at_first)
                        v = last_rec + v;
                    last_rec = v;
                    at_first = 1'b0;
                    recs_left--;
                    got = 1'b1;
                    if (recs_left == 0)
                    begin
                        rec = record_t'{v, 1'b1, 1'b1, ST_OK};
                        close_list(eod);
                    end
                    else if (eod)
                    begin
                        rec = record_t'{v, 1'b1, 1'b1, ST_EARLY};
                        restart_list();
                    end
                    else
                        rec = record_t'{v, 1'b1, 1'b0, ST_OK};
                end
            end
        end
    endtask

    // leaves tvalid high after the transaction; callers that stop sending lower it
    task automatic send_byte(input logic [7:0] b, input logic eod, input logic pinned,
                             input logic pinned_has, input record_t pinned_rec);
        logic    got;
        record_t rec;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (list_phase != PH_DRAIN)
            live_items++;
        decode_byte(b, eod, got, rec);
        if (pinned)
        begin
            if (pinned_has)
                expected_recs.insert(expected_recs.size(), pinned_rec);
        end
        else if (got)
            expected_recs.insert(expected_recs.size(), rec);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_recs.size() != 0);
    endtask

    task automatic set_mode(input logic mode);
        drain_results();
        // a byte with no result may still be in the pipe
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        delta_on = mode;
    endtask

    task automatic add_varint(input logic [31:0] v);
        int         n;
        logic [7:0] b;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        // occasionally a padded, non-minimal encoding
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(n, 5);
        for (int i = 0; i < n; i++)
        begin
            b = {1'b0, 7'(v >> (7 * i))};
            if (i < n - 1)
                b[CONT_BIT] = 1'b1;
            else if (i == 4 && $urandom_range(0, 1))
                b[6:4] = 3'($urandom_range(1, 7));
            burst_q.insert(burst_q.size(), b);
        end
    endtask

    task automatic send_list();
        int          kind;
        int          nrec;
        int          bad_at;
        int          cut;
        logic [31:0] count;
        burst_q.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 92)
        begin
            repeat ($urandom_range(1, 6))
                burst_q.insert(burst_q.size(), 8'($urandom));
        end
        else
        begin
            case ($urandom_range(0, 15))
                0:       count = 32'h0;
                1:       count = $urandom;
                default: count = $urandom_range(1, 8);
            endcase
            // huge counts can only end by running out of data or by a too-long varint
            nrec = (count > 8) ? $urandom_range(1, 6) : int'(count);
            bad_at = (kind < 8) ? $urandom_range(0, nrec) : -1;
            add_varint(count);
            for (int i = 0; i <= nrec; i++)
            begin
                if (i == bad_at)
                    repeat ($urandom_range(5, 7))
                        burst_q.insert(burst_q.size(), 8'h80 | 8'($urandom));
                if (i < nrec)
                    add_varint($urandom >> $urandom_range(0, 31));
            end
            if (kind >= 8 && kind < 16)
            begin
                cut = $urandom_range(1, burst_q.size());
                while (burst_q.size() > cut)
                    void'(burst_q.pop_back());
            end
            else if (kind >= 16 && kind < 26)
            begin
                repeat ($urandom_range(1, 4))
                    burst_q.insert(burst_q.size(), 8'($urandom));
            end
        end
        foreach (burst_q[i])
            send_byte(burst_q[i], i == burst_q.size() - 1, 1'b0, 1'b0, '0);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input logic mode,
                             input int target, input bit hold);
        bit paused;
        paused = 1'b0;
        set_mode(mode);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (hold)
            hold_asks <= hold_asks + 1;
        live_items = 0;
        while (live_items < target)
        begin
            send_list();
            if (!paused && live_items >= target / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    task automatic add_step(input logic [7:0] b, input logic eod, input logic pinned,
                            input logic has, input record_t rec);
        directed_steps.insert(directed_steps.size(), step_t'{b, eod, pinned, has, rec});
    endtask

    task automatic check_result();
        record_t want;
        if (expected_recs.size() == 0)
        begin
            $error("unexpected result: rec_value %h tuser %b last %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            err_count++;
        end
        else
        begin
            want = expected_recs.pop_front();
            if (m_axis_tdata !== want.value)
            begin
                $error("rec_value: expected %h, got %h", want.value, m_axis_tdata);
                err_count++;
            end
            if (m_axis_tuser[0] !== want.valid)
            begin
                $error("record_valid: expected %b, got %b", want.valid, m_axis_tuser[0]);
                err_count++;
            end
            if (m_axis_tlast !== want.last)
            begin
                $error("last_of_list: expected %b, got %b", want.last, m_axis_tlast);
                err_count++;
            end
            if (m_axis_tuser[2:1] !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:1]);
                err_count++;
            end
        end
    endtask

    initial
    begin : result_sink
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (hold_asks != hold_done)
            begin
                hold_done++;
                hold_left = 200;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        record_t none;
        none = '0;

        // zero count, then trailing bytes up to end of data
        add_step(8'h00, 1'b0, 1'b1, 1'b1, record_t'{32'h0, 1'b0, 1'b1, ST_EMPTY});
        add_step(8'hFF, 1'b1, 1'b1, 1'b0, none);
        // two records: all-ones with wide payload bits, then a gap that wraps to zero
        add_step(8'h02, 1'b0, 1'b1, 1'b0, none);
        add_step(8'hFF, 1'b0, 1'b1, 1'b0, none);
        add_step(8'hFF, 1'b0, 1'b1, 1'b0, none);
        add_step(8'hFF, 1'b0, 1'b1, 1'b0, none);
        add_step(8'hFF, 1'b0, 1'b1, 1'b0, none);
        add_step(8'h7F, 1'b0, 1'b1, 1'b1, record_t'{32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK});
        add_step(8'h01, 1'b0, 1'b1, 1'b1, record_t'{32'h0, 1'b1, 1'b1, ST_OK});
        add_step(8'h55, 1'b1, 1'b1, 1'b0, none);
        // count on the last byte of data
        add_step(8'h01, 1'b1, 1'b1, 1'b1, record_t'{32'h0, 1'b0, 1'b1, ST_EARLY});
        // long varint, end of data on the same byte
        add_step(8'h03, 1'b0, 1'b1, 1'b0, none);
        add_step(8'h80, 1'b0, 1'b1, 1'b0, none);
        add_step(8'h80, 1'b0, 1'b1, 1'b0, none);
        add_step(8'h80, 1'b0, 1'b1, 1'b0, none);
        add_step(8'h80, 1'b0, 1'b1, 1'b0, none);
        add_step(8'h80, 1'b1, 1'b1, 1'b1, record_t'{32'h0, 1'b0, 1'b1, ST_TOO_LONG});
        // partial varint closed by end of data, list truncated
        add_step(8'h02, 1'b0, 1'b0, 1'b0, none);
        add_step(8'h85, 1'b0, 1'b0, 1'b0, none);
        add_step(8'h81, 1'b1, 1'b0, 1'b0, none);
        // zero count with end of data, then a list of three cut short by end of data
        add_step(8'h00, 1'b1, 1'b1, 1'b1, record_t'{32'h0, 1'b0, 1'b1, ST_EMPTY});
        add_step(8'h03, 1'b0, 1'b0, 1'b0, none);
        add_step(8'h0A, 1'b0, 1'b0, 1'b0, none);
        add_step(8'h05, 1'b1, 1'b0, 1'b0, none);

        send_idle_pct = 17;
        recv_idle_pct = 62;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
            send_byte(directed_steps[i].data, directed_steps[i].eod, directed_steps[i].pinned,
                      directed_steps[i].pinned_has, directed_steps[i].rec);

        run_phase(17, 62, 1'b1, 290, 1'b0);
        run_phase(62, 17, 1'b0, 290, 1'b0);
        // output held off for a long stretch so the block backs up into its input
        run_phase(0, 0, 1'b1, 300, 1'b1);

        drain_results();
        repeat (6) @(posedge clk);
        if (err_count == 0)
            $display("delta_varint_list_decoder_test: clean");
        else
            $display("delta_varint_list_decoder_test: errors");
        $finish;
    end

endmodule
